/* hw/rtl/lsbsd_pkg.sv */
// lsbsd_pkg: shared types, constants and register indexes of the lsb stego bitmap decoder
// no dependencies; used by lsbsd_csr, lsbsd_parse and lsb_stego_bitmap_decoder_top
`default_nettype none

package lsbsd_pkg;

   // hidden field sizes
   localparam int MagicMax   = 8;
   localparam int LengthBits = 32;
   localparam int CharBits   = 8;

   // register widths
   localparam int MagicCharsW  = 64;
   localparam int MagicLengthW = 4;
   localparam int HeaderSkipW  = 10;
   localparam int CsrDataW     = 64;
   localparam int CsrAddrW     = 2;

   // parse state widths
   localparam int ByteCountW  = 10;
   localparam int BitIndexW   = 5;
   localparam int MagicIndexW = 3;

   // result field widths
   localparam int KindW  = 3;
   localparam int ValueW = 32;

   // register reset values ("#*", two chars, 54 byte bitmap header)
   localparam logic [MagicCharsW-1:0]  MagicCharsReset  = 64'd10787;
   localparam logic [MagicLengthW-1:0] MagicLengthReset = 4'd2;
   localparam logic [HeaderSkipW-1:0]  HeaderSkipReset  = 10'd54;

   // register indexes on the csr port
   typedef enum logic [CsrAddrW-1:0] {
      REG_MAGIC_CHARS  = 2'd0,
      REG_MAGIC_LENGTH = 2'd1,
      REG_HEADER_SKIP  = 2'd2
   } csr_index_type;

   // result kinds
   typedef enum logic [KindW-1:0] {
      KIND_MAGIC_OK    = 3'd0,
      KIND_MAGIC_BAD   = 3'd1,
      KIND_EXT_LEN     = 3'd2,
      KIND_EXT_CHAR    = 3'd3,
      KIND_PAY_LEN     = 3'd4,
      KIND_PAY_BYTE    = 3'd5
   } kind_type;

   // parse phases, one-hot
   typedef enum logic [6:0] {
      PH_SKIP     = 7'b0000001,
      PH_MAGIC    = 7'b0000010,
      PH_EXT_LEN  = 7'b0000100,
      PH_EXT_CHAR = 7'b0001000,
      PH_PAY_LEN  = 7'b0010000,
      PH_PAY_BYTE = 7'b0100000,
      PH_DONE     = 7'b1000000
   } phase_type;

   // configuration seen by the parser
   typedef struct packed {
      logic [MagicCharsW-1:0]  magic_chars;
      logic [MagicLengthW-1:0] magic_length;
      logic [HeaderSkipW-1:0]  header_skip;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic                 valid;
      kind_type             kind;
      logic [ValueW-1:0]    value;
      logic                 last_payload;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/lsbsd_csr.sv */
// lsbsd_csr: configuration registers of the lsb stego bitmap decoder
// depends on lsbsd_pkg
`default_nettype none

module lsbsd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [lsbsd_pkg::CsrAddrW-1:0] csr_addr,
   input  wire logic [lsbsd_pkg::CsrDataW-1:0] csr_wdata,
   output lsbsd_pkg::cfg_type                  cfg
);

   lsbsd_pkg::cfg_type cfg_ff;
   lsbsd_pkg::cfg_type cfg_in;

   // write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            lsbsd_pkg::REG_MAGIC_CHARS: begin
               cfg_in.magic_chars = csr_wdata[lsbsd_pkg::MagicCharsW-1:0];
            end
            lsbsd_pkg::REG_MAGIC_LENGTH: begin
               cfg_in.magic_length = csr_wdata[lsbsd_pkg::MagicLengthW-1:0];
            end
            lsbsd_pkg::REG_HEADER_SKIP: begin
               cfg_in.header_skip = csr_wdata[lsbsd_pkg::HeaderSkipW-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_chars  <= lsbsd_pkg::MagicCharsReset;
         cfg_ff.magic_length <= lsbsd_pkg::MagicLengthReset;
         cfg_ff.header_skip  <= lsbsd_pkg::HeaderSkipReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/lsbsd_parse.sv */
// lsbsd_parse: parse state and per-byte decode of the hidden fields
// depends on lsbsd_pkg; driven by the input register of the top level
`default_nettype none

module lsbsd_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lsbsd_pkg::cfg_type cfg,
   input  wire logic               step,
   input  wire logic               data_bit,
   input  wire logic               image_start,
   output lsbsd_pkg::result_type   result
);

   lsbsd_pkg::phase_type                  phase_ff, phase_in;
   logic [lsbsd_pkg::ByteCountW-1:0]      byte_count_ff, byte_count_in;
   logic [lsbsd_pkg::BitIndexW-1:0]       bit_index_ff, bit_index_in;
   logic [lsbsd_pkg::LengthBits-1:0]      bit_acc_ff, bit_acc_in;
   logic [lsbsd_pkg::LengthBits-1:0]      remaining_ff, remaining_in;
   logic [lsbsd_pkg::MagicIndexW-1:0]     magic_index_ff, magic_index_in;
   logic                                  magic_failed_ff, magic_failed_in;

   // state seen by this byte, after an image start clears the parse
   lsbsd_pkg::phase_type                  cur_phase;
   logic [lsbsd_pkg::ByteCountW-1:0]      cur_byte_count;
   logic [lsbsd_pkg::BitIndexW-1:0]       cur_bit_index;
   logic [lsbsd_pkg::LengthBits-1:0]      cur_bit_acc;
   logic [lsbsd_pkg::LengthBits-1:0]      cur_remaining;
   logic [lsbsd_pkg::MagicIndexW-1:0]     cur_magic_index;
   logic                                  cur_magic_failed;

   lsbsd_pkg::phase_type                  work_phase;
   logic                                  gather;
   logic                                  wide;
   logic                                  word_done;
   logic [lsbsd_pkg::BitIndexW-1:0]       index_next;
   logic [lsbsd_pkg::LengthBits-1:0]      acc_next;
   logic [lsbsd_pkg::LengthBits-1:0]      word;
   logic [lsbsd_pkg::LengthBits-1:0]      remaining_dec;
   logic [lsbsd_pkg::MagicLengthW-1:0]    magic_len;
   logic [lsbsd_pkg::MagicLengthW-1:0]    magic_count;
   logic [lsbsd_pkg::CharBits-1:0]        magic_expect;
   logic                                  mismatch_seen;

   // restart on image start
   always_comb begin
      if (image_start) begin
         cur_phase        = lsbsd_pkg::PH_SKIP;
         cur_byte_count   = '0;
         cur_bit_index    = '0;
         cur_bit_acc      = '0;
         cur_remaining    = '0;
         cur_magic_index  = '0;
         cur_magic_failed = 1'b0;
      end else begin
         cur_phase        = phase_ff;
         cur_byte_count   = byte_count_ff;
         cur_bit_index    = bit_index_ff;
         cur_bit_acc      = bit_acc_ff;
         cur_remaining    = remaining_ff;
         cur_magic_index  = magic_index_ff;
         cur_magic_failed = magic_failed_ff;
      end
   end

   // clamp the magic length to 1..MagicMax
   always_comb begin
      if (cfg.magic_length == '0) begin
         magic_len = lsbsd_pkg::MagicLengthW'(1);
      end else if (cfg.magic_length > lsbsd_pkg::MagicLengthW'(lsbsd_pkg::MagicMax)) begin
         magic_len = lsbsd_pkg::MagicLengthW'(lsbsd_pkg::MagicMax);
      end else begin
         magic_len = cfg.magic_length;
      end
   end

   // bit gathering shared by all data phases
   always_comb begin
      work_phase    = (cur_phase == lsbsd_pkg::PH_SKIP) ? lsbsd_pkg::PH_MAGIC : cur_phase;
      wide          = (work_phase == lsbsd_pkg::PH_EXT_LEN) ||
                      (work_phase == lsbsd_pkg::PH_PAY_LEN);
      acc_next      = cur_bit_acc |
                      (lsbsd_pkg::LengthBits'(data_bit) << cur_bit_index);
      index_next    = cur_bit_index + lsbsd_pkg::BitIndexW'(1);
      word_done     = (index_next == '0) ||
                      (!wide && index_next >= lsbsd_pkg::BitIndexW'(lsbsd_pkg::CharBits));
      word          = wide ? acc_next
                           : {{(lsbsd_pkg::LengthBits-lsbsd_pkg::CharBits){1'b0}},
                              acc_next[lsbsd_pkg::CharBits-1:0]};
      remaining_dec = cur_remaining - lsbsd_pkg::LengthBits'(1);
      magic_expect  = cfg.magic_chars[{cur_magic_index, 3'b000} +: lsbsd_pkg::CharBits];
      mismatch_seen = cur_magic_failed ||
                      (word[lsbsd_pkg::CharBits-1:0] != magic_expect);
      magic_count   = {1'b0, cur_magic_index} + lsbsd_pkg::MagicLengthW'(1);
   end

   // phase sequencing and result decode
   always_comb begin
      phase_in        = cur_phase;
      byte_count_in   = cur_byte_count;
      bit_index_in    = cur_bit_index;
      bit_acc_in      = cur_bit_acc;
      remaining_in    = cur_remaining;
      magic_index_in  = cur_magic_index;
      magic_failed_in = cur_magic_failed;
      gather          = 1'b0;
      result          = '0;

      unique case (cur_phase)
         lsbsd_pkg::PH_DONE: begin
            gather = 1'b0;
         end
         lsbsd_pkg::PH_SKIP: begin
            if (cur_byte_count < cfg.header_skip) begin
               byte_count_in = cur_byte_count + lsbsd_pkg::ByteCountW'(1);
            end else begin
               phase_in = lsbsd_pkg::PH_MAGIC;
               gather   = 1'b1;
            end
         end
         lsbsd_pkg::PH_MAGIC, lsbsd_pkg::PH_EXT_LEN, lsbsd_pkg::PH_EXT_CHAR,
         lsbsd_pkg::PH_PAY_LEN, lsbsd_pkg::PH_PAY_BYTE: begin
            gather = 1'b1;
         end
         default: begin
            phase_in = lsbsd_pkg::PH_DONE;
         end
      endcase

      if (gather) begin
         if (!word_done) begin
            bit_acc_in   = acc_next;
            bit_index_in = index_next;
         end else begin
            bit_acc_in   = '0;
            bit_index_in = '0;
            unique case (work_phase)
               // magic chars: one verdict after the last one
               lsbsd_pkg::PH_MAGIC: begin
                  magic_failed_in = mismatch_seen;
                  if (magic_count >= magic_len) begin
                     magic_index_in = '0;
                     phase_in       = mismatch_seen ? lsbsd_pkg::PH_DONE
                                                    : lsbsd_pkg::PH_EXT_LEN;
                     result.valid   = 1'b1;
                     result.kind    = mismatch_seen ? lsbsd_pkg::KIND_MAGIC_BAD
                                                    : lsbsd_pkg::KIND_MAGIC_OK;
                  end else begin
                     magic_index_in = cur_magic_index + lsbsd_pkg::MagicIndexW'(1);
                  end
               end
               lsbsd_pkg::PH_EXT_LEN: begin
                  remaining_in = word;
                  phase_in     = (word == '0) ? lsbsd_pkg::PH_PAY_LEN
                                              : lsbsd_pkg::PH_EXT_CHAR;
                  result.valid = 1'b1;
                  result.kind  = lsbsd_pkg::KIND_EXT_LEN;
                  result.value = word;
               end
               lsbsd_pkg::PH_EXT_CHAR: begin
                  remaining_in = remaining_dec;
                  if (remaining_dec == '0) begin
                     phase_in = lsbsd_pkg::PH_PAY_LEN;
                  end
                  result.valid = 1'b1;
                  result.kind  = lsbsd_pkg::KIND_EXT_CHAR;
                  result.value = word;
               end
               lsbsd_pkg::PH_PAY_LEN: begin
                  remaining_in        = word;
                  phase_in            = (word == '0) ? lsbsd_pkg::PH_DONE
                                                     : lsbsd_pkg::PH_PAY_BYTE;
                  result.valid        = 1'b1;
                  result.kind         = lsbsd_pkg::KIND_PAY_LEN;
                  result.value        = word;
                  result.last_payload = (word == '0);
               end
               lsbsd_pkg::PH_PAY_BYTE: begin
                  remaining_in = remaining_dec;
                  if (remaining_dec == '0) begin
                     phase_in = lsbsd_pkg::PH_DONE;
                  end
                  result.valid        = 1'b1;
                  result.kind         = lsbsd_pkg::KIND_PAY_BYTE;
                  result.value        = word;
                  result.last_payload = (remaining_dec == '0);
               end
               default: begin
                  phase_in = lsbsd_pkg::PH_DONE;
               end
            endcase
         end
      end

      if (!step) begin
         result.valid = 1'b0;
      end
   end

   // parse state advances once per processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lsbsd_pkg::PH_SKIP;
         byte_count_ff   <= '0;
         bit_index_ff    <= '0;
         bit_acc_ff      <= '0;
         remaining_ff    <= '0;
         magic_index_ff  <= '0;
         magic_failed_ff <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         bit_index_ff    <= bit_index_in;
         bit_acc_ff      <= bit_acc_in;
         remaining_ff    <= remaining_in;
         magic_index_ff  <= magic_index_in;
         magic_failed_ff <= magic_failed_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lsb_stego_bitmap_decoder_top.sv */
// lsb_stego_bitmap_decoder_top: stream wrapper with input and result registers
// depends on lsbsd_pkg, lsbsd_csr and lsbsd_parse
`default_nettype none

// Decodes data hidden in the least significant bits of a bitmap file stream.
// One file byte is taken per transfer; after header_skip bytes, bit 0 of each
// byte is gathered, eight bits to a character and 32 to a length word, giving
// magic verdict, extension length and chars, payload length and payload bytes.
// The block takes one byte every clock unless a result waits on rsp_tready:
// a byte is held in the input register, the parse logic decodes it against
// the stored field state and the result register holds at most one result
// per byte for rsp; both stall only on rsp_tready. The user writes registers
// on the csr port only while no byte is in flight; the block does not check.
module lsb_stego_bitmap_decoder_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input stream
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,  // [7:0] pixel_byte
   input  wire logic                           req_tuser,  // [0] image_start
   // result stream
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [31:0]                    rsp_tdata,  // [31:0] value
   output      logic [2:0]                     rsp_tuser,  // [2:0] kind
   output      logic                           rsp_tlast,  // last_payload
   // configuration writes
   input  wire logic                           csr_we,
   input  wire logic [lsbsd_pkg::CsrAddrW-1:0] csr_addr,
   input  wire logic [lsbsd_pkg::CsrDataW-1:0] csr_wdata
);

   lsbsd_pkg::cfg_type    cfg;
   lsbsd_pkg::result_type result;

   logic in_valid_ff, in_valid_in;
   logic in_bit_ff;
   logic in_start_ff;
   logic out_valid_ff, out_valid_in;
   logic [lsbsd_pkg::ValueW-1:0] out_value_ff;
   logic [lsbsd_pkg::KindW-1:0]  out_kind_ff;
   logic                         out_last_ff;
   logic step;
   logic req_xfer;

   lsbsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsbsd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (step),
      .data_bit    (in_bit_ff),
      .image_start (in_start_ff),
      .result      (result)
   );

   // handshake: the held byte moves on when the result register is free
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (step) begin
         out_valid_in = result.valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input payload register, only bit 0 carries data
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_bit_ff   <= req_tdata[0];
         in_start_ff <= req_tuser;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         out_value_ff <= result.value;
         out_kind_ff  <= result.kind;
         out_last_ff  <= result.last_payload;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire
